/* sv/cfp_pkg.sv */
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared types and character codes for the CIGAR 5-prime position unit.
// ----------------------------------------------------------------------------
package cfp_pkg;

    localparam int OUT_BITS = 33;
    localparam int POS_BITS = 31;

    // Largest 5-prime position a reverse-strand result may take
    localparam logic [OUT_BITS-1:0] POS_TOP = 33'h0_FFFF_FFFF;

    localparam logic [7:0] CHAR_0  = 8'h30;
    localparam logic [7:0] CHAR_9  = 8'h39;
    localparam logic [7:0] CHAR_M  = 8'h4D;
    localparam logic [7:0] CHAR_D  = 8'h44;
    localparam logic [7:0] CHAR_N  = 8'h4E;
    localparam logic [7:0] CHAR_X  = 8'h58;
    localparam logic [7:0] CHAR_EQ = 8'h3D;
    localparam logic [7:0] CHAR_S  = 8'h53;
    localparam logic [7:0] CHAR_H  = 8'h48;

    typedef struct packed {
        logic [7:0]          cigar_char;
        logic                last_char;
        logic                reverse_strand;
        logic [POS_BITS-1:0] start_pos;
    } item_t;

    typedef struct packed {
        logic                       load;
        logic signed [OUT_BITS-1:0] adjusted_pos;
    } result_t;

endpackage

/* sv/cfp_in_reg.sv */
// ----------------------------------------------------------------------------
// cfp_in_reg
// Input register: captures one character transaction per cycle while in_ready is high.
// ----------------------------------------------------------------------------
module cfp_in_reg
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  cfp_pkg::item_t item,
    input  logic          advance,
    output logic          stage_valid,
    output cfp_pkg::item_t stage_item
);

    logic           valid_reg;
    logic           valid_next;
    cfp_pkg::item_t item_reg;

    assign in_ready    = !valid_reg || advance;
    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item;
        end
    end

endmodule

/* sv/cfp_parse.sv */
// ----------------------------------------------------------------------------
// cfp_parse
// Per-string parse state: operation length, reference span and leading
// clip, plus the 5-prime position computed on the final character.
// ----------------------------------------------------------------------------
module cfp_parse #(
    parameter int OP_LEN_BITS = 28,
    parameter int SPAN_BITS   = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  cfp_pkg::item_t   item,
    output cfp_pkg::result_t result
);

    localparam int DW = OP_LEN_BITS + 4;
    localparam int AW = ((SPAN_BITS > OP_LEN_BITS) ? SPAN_BITS : OP_LEN_BITS) + 1;
    localparam int RW = ((SPAN_BITS > 32) ? SPAN_BITS : 32) + 2;
    localparam int FW = ((OP_LEN_BITS > 31) ? OP_LEN_BITS : 31) + 2;
    localparam int OW = cfp_pkg::OUT_BITS;

    logic [OP_LEN_BITS-1:0] digit_accum_reg;
    logic [OP_LEN_BITS-1:0] digit_accum_next;
    logic [SPAN_BITS-1:0]   span_sum_reg;
    logic [SPAN_BITS-1:0]   span_sum_next;
    logic                   char_index_nonzero_reg;
    logic                   char_index_nonzero_next;
    logic                   first_is_digit_reg;
    logic                   first_is_digit_next;
    logic                   first_op_seen_reg;
    logic                   first_op_seen_next;
    logic                   leading_clip_valid_reg;
    logic                   leading_clip_valid_next;
    logic [OP_LEN_BITS-1:0] leading_clip_len_reg;
    logic [OP_LEN_BITS-1:0] leading_clip_len_next;

    logic                   is_digit;
    logic                   is_clip;
    logic                   is_span_op;
    logic [7:0]             digit_val;
    logic [DW-1:0]          acc_ext;
    logic [DW-1:0]          acc_mac;
    logic [AW-1:0]          span_add;
    logic signed [RW-1:0]   rev_sum;
    logic signed [RW-1:0]   rev_top;
    logic signed [FW-1:0]   fwd_diff;
    logic signed [OW-1:0]   pos_out;

    always_comb
    begin
        is_digit   = (item.cigar_char >= cfp_pkg::CHAR_0) &&
                     (item.cigar_char <= cfp_pkg::CHAR_9);
        is_clip    = (item.cigar_char == cfp_pkg::CHAR_S) ||
                     (item.cigar_char == cfp_pkg::CHAR_H);
        is_span_op = (item.cigar_char == cfp_pkg::CHAR_M) ||
                     (item.cigar_char == cfp_pkg::CHAR_D) ||
                     (item.cigar_char == cfp_pkg::CHAR_N) ||
                     (item.cigar_char == cfp_pkg::CHAR_X) ||
                     (item.cigar_char == cfp_pkg::CHAR_EQ);
        digit_val  = item.cigar_char - cfp_pkg::CHAR_0;

        // length * 10 + digit as shift-add, saturate on overflow
        acc_ext = DW'(digit_accum_reg);
        acc_mac = (acc_ext << 3) + (acc_ext << 1) + DW'(digit_val[3:0]);

        span_add = AW'(span_sum_reg) + AW'(digit_accum_reg);

        char_index_nonzero_next = 1'b1;
        first_is_digit_next     = char_index_nonzero_reg ? first_is_digit_reg : is_digit;
        first_op_seen_next      = first_op_seen_reg;
        leading_clip_valid_next = leading_clip_valid_reg;
        leading_clip_len_next   = leading_clip_len_reg;
        span_sum_next           = span_sum_reg;

        if (is_digit)
        begin
            if (acc_mac[DW-1:OP_LEN_BITS] != '0)
            begin
                digit_accum_next = '1;
            end
            else
            begin
                digit_accum_next = acc_mac[OP_LEN_BITS-1:0];
            end
        end
        else
        begin
            digit_accum_next = '0;
            if (!first_op_seen_reg)
            begin
                first_op_seen_next      = 1'b1;
                leading_clip_valid_next = first_is_digit_next && is_clip;
                leading_clip_len_next   = digit_accum_reg;
            end
            if (is_span_op || (is_clip && item.last_char))
            begin
                if (span_add[AW-1:SPAN_BITS] != '0)
                begin
                    span_sum_next = '1;
                end
                else
                begin
                    span_sum_next = span_add[SPAN_BITS-1:0];
                end
            end
        end
    end

    // 5-prime position from the updated state
    always_comb
    begin
        rev_top  = RW'(cfp_pkg::POS_TOP);
        rev_sum  = $signed(RW'(item.start_pos)) + $signed(RW'(span_sum_next))
                   - $signed(RW'(1));
        fwd_diff = $signed(FW'(item.start_pos)) - $signed(FW'(leading_clip_len_next));

        if (item.reverse_strand)
        begin
            if (rev_sum > rev_top)
            begin
                pos_out = $signed(cfp_pkg::POS_TOP);
            end
            else
            begin
                pos_out = rev_sum[OW-1:0];
            end
        end
        else if (leading_clip_valid_next)
        begin
            if (fwd_diff <= $signed(FW'(0)))
            begin
                pos_out = $signed(OW'(1));
            end
            else
            begin
                pos_out = fwd_diff[OW-1:0];
            end
        end
        else
        begin
            pos_out = $signed(OW'(item.start_pos));
        end

        result.load         = advance && item.last_char;
        result.adjusted_pos = pos_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_accum_reg        <= '0;
            span_sum_reg           <= '0;
            char_index_nonzero_reg <= 1'b0;
            first_is_digit_reg     <= 1'b0;
            first_op_seen_reg      <= 1'b0;
            leading_clip_valid_reg <= 1'b0;
            leading_clip_len_reg   <= '0;
        end
        else if (advance)
        begin
            if (item.last_char)
            begin
                // clear for the next string
                digit_accum_reg        <= '0;
                span_sum_reg           <= '0;
                char_index_nonzero_reg <= 1'b0;
                first_is_digit_reg     <= 1'b0;
                first_op_seen_reg      <= 1'b0;
                leading_clip_valid_reg <= 1'b0;
                leading_clip_len_reg   <= '0;
            end
            else
            begin
                digit_accum_reg        <= digit_accum_next;
                span_sum_reg           <= span_sum_next;
                char_index_nonzero_reg <= char_index_nonzero_next;
                first_is_digit_reg     <= first_is_digit_next;
                first_op_seen_reg      <= first_op_seen_next;
                leading_clip_valid_reg <= leading_clip_valid_next;
                leading_clip_len_reg   <= leading_clip_len_next;
            end
        end
    end

endmodule

/* sv/cfp_out_reg.sv */
// ----------------------------------------------------------------------------
// cfp_out_reg
// Result register: holds one position until the downstream side takes it.
// ----------------------------------------------------------------------------
module cfp_out_reg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  cfp_pkg::result_t                    result,
    output logic                                out_free,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [cfp_pkg::OUT_BITS-1:0] adjusted_pos
);

    logic                                valid_reg;
    logic                                valid_next;
    logic signed [cfp_pkg::OUT_BITS-1:0] pos_reg;

    assign out_free     = !valid_reg || out_ready;
    assign out_valid    = valid_reg;
    assign adjusted_pos = pos_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (result.load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.load)
        begin
            pos_reg <= result.adjusted_pos;
        end
    end

endmodule

/* sv/cigar_five_prime_position_unit.sv */
// ----------------------------------------------------------------------------
// cigar_five_prime_position_unit
// Streams a CIGAR string one character per cycle, unless a final character is
// stalled, and returns the 5-prime mapped position after the final character.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  in      | input     | in_valid / in_ready  | cigar_char, last_char,
//          |           |                      | reverse_strand, start_pos
//  out     | output    | out_valid / out_ready| adjusted_pos (33-bit signed)
//
//  One character per cycle while not stalled; a result passes from its final
//  character through the input register, parse logic and result register.
//  Non-final characters in the input register never wait on the output side.
//  Reset clears all string state; after every final character it clears too.
//  A held result stalls only a final character sitting in the input register.
// ----------------------------------------------------------------------------
module cigar_five_prime_position_unit #(
    parameter int OP_LEN_BITS = 28,
    parameter int SPAN_BITS   = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          cigar_char,
    input  logic                                last_char,
    input  logic                                reverse_strand,
    input  logic [cfp_pkg::POS_BITS-1:0]        start_pos,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [cfp_pkg::OUT_BITS-1:0] adjusted_pos
);

    cfp_pkg::item_t   in_item;
    cfp_pkg::item_t   stage_item;
    cfp_pkg::result_t result;
    logic             stage_valid;
    logic             advance;
    logic             out_free;

    assign in_item.cigar_char     = cigar_char;
    assign in_item.last_char      = last_char;
    assign in_item.reverse_strand = reverse_strand;
    assign in_item.start_pos      = start_pos;

    // a final character needs room in the result register
    assign advance = stage_valid && (!stage_item.last_char || out_free);

    cfp_in_reg u_in_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .item        (in_item),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    cfp_parse #(
        .OP_LEN_BITS (OP_LEN_BITS),
        .SPAN_BITS   (SPAN_BITS)
    ) u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (stage_item),
        .result  (result)
    );

    cfp_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .result       (result),
        .out_free     (out_free),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .adjusted_pos (adjusted_pos)
    );

endmodule

/* sv/cfp_checker.sv */
// ----------------------------------------------------------------------------
// cfp_checker
// Port-level checks for the CIGAR 5-prime position unit.
// ----------------------------------------------------------------------------
module cfp_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                last_char,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [cfp_pkg::OUT_BITS-1:0] adjusted_pos
);

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(adjusted_pos))
    else $error("result changed while stalled");

    // a fresh result comes from a taken final character
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && last_char, 2))
    else $error("result without a final character");

    // input back-pressure only while a result is held
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

    // the only negative position is -1
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && adjusted_pos[cfp_pkg::OUT_BITS-1]
            |-> adjusted_pos == {cfp_pkg::OUT_BITS{1'b1}})
    else $error("negative position other than -1");

endmodule

bind cigar_five_prime_position_unit cfp_checker u_cfp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .last_char    (last_char),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .adjusted_pos (adjusted_pos)
);
